// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the distance lookup RTL
// Clocked concurrent checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset
`define PQDT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pqdt: property violated");

// Condition in one cycle implies a consequence in the next
`define PQDT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pqdt: next-cycle property violated");

`endif

// ----- sv/pqdt_pkg.sv -----
// ----------------------------------------------------------------------------
// pqdt_pkg
// Sizes, types and codes of the product-quantization distance lookup.
// ----------------------------------------------------------------------------
package pqdt_pkg;

  // Table geometry and entry format
  localparam int unsigned CODEBOOK_ROWS = 256;
  localparam int unsigned SUBQUANTIZERS = 16;
  localparam int unsigned DIST_BITS     = 24;

  // Field widths fixed by the item format
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned COL_BITS   = 4;
  localparam int unsigned VALUE_BITS = 24;
  localparam int unsigned ID_BITS    = 32;
  localparam int unsigned SUM_BITS   = 28;

  // Derived widths
  localparam int unsigned ROW_BITS   = $clog2(CODEBOOK_ROWS);
  localparam int unsigned ROWCNT_W   = ROW_BITS + 1;
  localparam int unsigned LANE_GROUP = 4;
  localparam int unsigned NUM_GROUPS = (SUBQUANTIZERS + LANE_GROUP - 1) / LANE_GROUP;
  localparam int unsigned GROUP_W    = DIST_BITS + $clog2(LANE_GROUP);
  localparam int unsigned TOTAL_W    = DIST_BITS + 4;
  localparam int unsigned SAT_W      = (TOTAL_W > SUM_BITS) ? TOTAL_W : SUM_BITS;

  // Saturated distance, also the padding distance
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
  // Identifier returned for padding
  localparam logic signed [ID_BITS-1:0] PAD_ID = -32'sd1;

  // Item kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [GROUP_W-1:0]   group_sum_t;

  // Per-item controls from the top level to the table banks
  typedef struct packed {
    logic load_en;
    logic lookup_en;
  } pqdt_ctrl_t;

endpackage

// ----- sv/pqdt_in_if.sv -----
// ----------------------------------------------------------------------------
// pqdt_in_if
// Input channel: load and lookup words with valid/ready.
// ----------------------------------------------------------------------------
interface pqdt_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         column_index;
  logic [7:0]         row_index;
  logic [23:0]        table_value;
  logic [63:0]        codes_low;
  logic [63:0]        codes_high;
  logic signed [31:0] vector_id;
  logic               pad;

  modport source (
    output valid, action, column_index, row_index, table_value,
           codes_low, codes_high, vector_id, pad,
    input  ready
  );

  modport sink (
    input  valid, action, column_index, row_index, table_value,
           codes_low, codes_high, vector_id, pad,
    output ready
  );
endinterface

// ----- sv/pqdt_out_if.sv -----
// ----------------------------------------------------------------------------
// pqdt_out_if
// Result channel: vector ID and distance with valid/ready.
// ----------------------------------------------------------------------------
interface pqdt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_id;
  logic [27:0]        distance;

  modport source (
    output valid, result_id, distance,
    input  ready
  );

  modport sink (
    input  valid, result_id, distance,
    output ready
  );
endinterface

// ----- sv/pq_distance_table_lookup_core.sv -----
// ----------------------------------------------------------------------------
// pq_distance_table_lookup_core
// Product-quantization distance lookup, one processing element.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries two kinds of words. A load word (action 0) writes one entry
//   of the 16 x 256 distance table and gives no result. A lookup word
//   (action 1) gives one result word on out_o: the vector ID and the sum of
//   the sixteen entries its codes select, saturated to 28 bits. A padded
//   lookup returns ID -1 and the all-ones distance.
//   A lookup passes the bank read register, the group sum register and the
//   output register in that order before its result shows on out_o.
//   One word per cycle while out_o is not stalled, loads and lookups mixed
//   freely; a lookup right after a load sees the new entry. The rate is set by
//   the single read port of each column bank, which serves one code per cycle.
//   The table must be loaded before it is read; it is not cleared at reset.
//   Reset empties the pipeline. When out_o is stalled with a result waiting,
//   the whole pipeline holds and in_i.ready drops in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pq_distance_table_lookup_core import pqdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pqdt_in_if.sink   in_i,
  pqdt_out_if.source out_o
);

  logic               advance;
  logic               in_fire;
  pqdt_ctrl_t         ctrl;
  dist_t              lane [SUBQUANTIZERS];
  logic [TOTAL_W-1:0] sum;
  logic [SAT_W-1:0]   sum_wide;
  logic [SUM_BITS-1:0] sat_dist;

  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_pad_q;
  logic signed [ID_BITS-1:0] s1_id_q;
  logic                      s2_valid_q;
  logic                      s2_pad_q;
  logic signed [ID_BITS-1:0] s2_id_q;
  logic                      out_valid_q;
  logic signed [ID_BITS-1:0] out_id_q, out_id_d;
  logic [SUM_BITS-1:0]       out_dist_q, out_dist_d;

  // Whole pipeline moves unless a result is waiting and stalled
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign in_fire    = in_i.valid && advance;

  assign ctrl.load_en   = in_fire && (in_i.action == ACT_LOAD);
  assign ctrl.lookup_en = in_fire && (in_i.action == ACT_LOOKUP);
  assign s1_valid_d     = ctrl.lookup_en;

  // Table banks with registered reads
  pqdt_table u_table (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .column_index_i (in_i.column_index),
    .row_index_i    (in_i.row_index),
    .table_value_i  (in_i.table_value),
    .codes_low_i    (in_i.codes_low),
    .codes_high_i   (in_i.codes_high),
    .lane_o         (lane)
  );

  // Adder tree
  pqdt_adder u_adder (
    .clk_i     (clk_i),
    .advance_i (advance),
    .lane_i    (lane),
    .sum_o     (sum)
  );

  // Saturation and padding override
  assign sum_wide   = SAT_W'(sum);
  assign sat_dist   = (sum_wide > SAT_W'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);
  assign out_dist_d = s2_pad_q ? SUM_MAX : sat_dist;
  assign out_id_d   = s2_pad_q ? PAD_ID : s2_id_q;

  // Valid bits of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Sideband and result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pad_q   <= in_i.pad;
      s1_id_q    <= in_i.vector_id;
      s2_pad_q   <= s1_pad_q;
      s2_id_q    <= s1_id_q;
      out_id_q   <= out_id_d;
      out_dist_q <= out_dist_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.result_id = out_id_q;
  assign out_o.distance  = out_dist_q;

  // Checks
  `PQDT_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, ctrl.load_en, !s1_valid_q)
  `PQDT_ASSERT_NEXT(a_no_phantom_out, clk_i, rst_ni, advance && !s2_valid_q, !out_valid_q)
  `PQDT_ASSERT_NEXT(a_pad_result, clk_i, rst_ni, advance && s2_valid_q && s2_pad_q, out_o.distance == SUM_MAX && out_o.result_id == PAD_ID)
  `PQDT_ASSERT(a_ready_when_empty, clk_i, rst_ni, out_valid_q || in_i.ready)

endmodule

// ----- sv/pqdt_ram.sv -----
// ----------------------------------------------------------------------------
// pqdt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pqdt_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sv/pqdt_table.sv -----
// ----------------------------------------------------------------------------
// pqdt_table
// Distance table split into one RAM bank per subquantizer column; a lookup
// reads all banks in parallel, one row per code.
// ----------------------------------------------------------------------------
module pqdt_table import pqdt_pkg::*; (
  input  logic                  clk_i,
  input  pqdt_ctrl_t            ctrl_i,
  input  logic [COL_BITS-1:0]   column_index_i,
  input  logic [CODE_BITS-1:0]  row_index_i,
  input  logic [VALUE_BITS-1:0] table_value_i,
  input  logic [63:0]           codes_low_i,
  input  logic [63:0]           codes_high_i,
  output dist_t                 lane_o [SUBQUANTIZERS]
);

  logic [127:0] codes;
  logic         row_ok;
  dist_t        wr_value;

  assign codes    = {codes_high_i, codes_low_i};
  assign row_ok   = {1'b0, row_index_i} < (CODE_BITS + 1)'(CODEBOOK_ROWS);
  assign wr_value = DIST_BITS'(table_value_i);

  for (genvar c = 0; c < SUBQUANTIZERS; c++) begin : g_bank
    logic [CODE_BITS-1:0] code;
    logic                 code_ok;
    logic                 code_ok_q;
    logic                 we;
    dist_t                rdata;

    assign code    = codes[c*CODE_BITS +: CODE_BITS];
    assign code_ok = {1'b0, code} < (CODE_BITS + 1)'(CODEBOOK_ROWS);
    assign we      = ctrl_i.load_en && row_ok && (column_index_i == COL_BITS'(c));

    pqdt_ram #(
      .Width (DIST_BITS),
      .Depth (CODEBOOK_ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (row_index_i[ROW_BITS-1:0]),
      .wdata_i (wr_value),
      .re_i    (ctrl_i.lookup_en),
      .raddr_i (code[ROW_BITS-1:0]),
      .rdata_o (rdata)
    );

    // Out-of-range code contributes zero
    always_ff @(posedge clk_i) begin
      if (ctrl_i.lookup_en) begin
        code_ok_q <= code_ok;
      end
    end

    assign lane_o[c] = code_ok_q ? rdata : '0;
  end

endmodule

// ----- sv/pqdt_adder.sv -----
// ----------------------------------------------------------------------------
// pqdt_adder
// Registered two-level adder tree: groups of four lanes are summed into a
// register, the group sums are added combinationally at the output.
// ----------------------------------------------------------------------------
module pqdt_adder import pqdt_pkg::*; (
  input  logic               clk_i,
  input  logic               advance_i,
  input  dist_t              lane_i [SUBQUANTIZERS],
  output logic [TOTAL_W-1:0] sum_o
);

  group_sum_t term    [NUM_GROUPS][LANE_GROUP];
  group_sum_t group_d [NUM_GROUPS];
  group_sum_t group_q [NUM_GROUPS];

  // Map lanes onto group slots, unused slots are zero
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    for (genvar k = 0; k < LANE_GROUP; k++) begin : g_slot
      if (g * LANE_GROUP + k < SUBQUANTIZERS) begin : g_used
        assign term[g][k] = GROUP_W'(lane_i[g * LANE_GROUP + k]);
      end else begin : g_unused
        assign term[g][k] = '0;
      end
    end
  end

  // First level: per-group sums
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_d[g] = '0;
      for (int k = 0; k < LANE_GROUP; k++) begin
        group_d[g] = group_d[g] + term[g][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      group_q <= group_d;
    end
  end

  // Second level: sum of group sums
  always_comb begin
    sum_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      sum_o = sum_o + TOTAL_W'(group_q[g]);
    end
  end

endmodule
